// ===== hdl/key_matrix_event_generator_assert.svh =====
// Assertion macros shared by the checkers of the key matrix event generator.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef KEY_MATRIX_EVENT_GENERATOR_ASSERT_SVH
`define KEY_MATRIX_EVENT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMEG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KMEG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/kmeg_pkg.sv =====
// Package for the key matrix event generator: item types, codes and defaults.
// Used by the top module of the block, by its checker and by the testbench; depends on nothing.
package kmeg_pkg;

	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 8;

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [7:0] MOD_LEFT_BASE  = 8'hE0;
	localparam logic [7:0] MOD_RIGHT_BASE = 8'hE4;
	localparam logic [3:0] NIB_LEFT       = 4'h0;
	localparam logic [3:0] NIB_RIGHT      = 4'h1;

	typedef struct packed {
		logic        op;
		logic [3:0]  row;
		logic [7:0]  col_levels;
		logic        end_of_scan;
		logic [2:0]  map_col;
		logic [15:0] map_code;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] usage;
		logic       pressed;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_CODE,
		ST_EMIT,
		ST_REPORT
	} state_t;

endpackage

// ===== hdl/key_matrix_event_generator.sv =====
// Key matrix event generator: turns scanned row levels into key usage items.
// A keymap write is taken in the idle state. A scan row goes through load and scan,
// then code and emit per changed column, modifier items first; a report comes last.
// The sequencer reads the pressed-key memory, then the keymap, one column at a time.
// Results leave through one output register.
// Reset clears all pressed bits (per-row valid flops) and the scan-changed flag.
module key_matrix_event_generator #(
	parameter int ROWS = kmeg_pkg::ROWS_DEF,
	parameter int COLS = kmeg_pkg::COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  kmeg_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output kmeg_pkg::out_item_t  result
);

	localparam int ROW_AW = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int COL_AW = COLS > 1 ? $clog2(COLS) : 1;
	localparam int KM_DEPTH = ROWS * COLS;
	localparam int KM_AW = KM_DEPTH > 1 ? $clog2(KM_DEPTH) : 1;

	kmeg_pkg::state_t state_q, state_nx;

	logic [3:0]      row_q;
	logic            row_ok_q;
	logic [COLS-1:0] lev_q;
	logic            eos_q;
	logic [COLS-1:0] now_q;
	logic [COLS-1:0] diff_q;
	logic            changed_q;
	logic            press_q;
	logic [3:0]      mods_q;
	logic            right_q;
	logic [7:0]      usage_q;
	logic            result_valid_q;
	kmeg_pkg::out_item_t result_q;

	logic            accept;
	logic            item_row_ok;
	logic            ks_rd_en;
	logic            ks_wr_en;
	logic [COLS-1:0] ks_rd_data;
	logic [COLS-1:0] now_d;
	logic [COLS-1:0] diff_d;
	logic            km_wr_en;
	logic            km_rd_en;
	logic [KM_AW-1:0] km_wr_addr;
	logic [KM_AW-1:0] km_rd_addr;
	logic [15:0]     km_rd_data;
	logic [COL_AW-1:0] col_sel;
	logic [1:0]      mod_sel;
	logic            slot_free;
	logic            emit;
	kmeg_pkg::out_item_t emit_item;
	logic [3:0]      mods_d;

	assign accept      = item_valid && item_ready;
	assign item_row_ok = {1'b0, item.row} < 5'(ROWS);
	assign slot_free   = !result_valid_q || result_ready;

	// Lowest changed column still to be served.
	always_comb begin
		col_sel = '0;
		for (int c = COLS - 1; c >= 0; c--) begin
			if (diff_q[c]) begin
				col_sel = COL_AW'(c);
			end
		end
	end

	// Lowest modifier bit still to be sent.
	always_comb begin
		mod_sel = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (mods_q[i]) begin
				mod_sel = 2'(i);
			end
		end
	end

	assign now_d  = ~lev_q;
	assign diff_d = row_ok_q ? (ks_rd_data ^ now_d) : '0;

	// Modifier bits count only when the top nibble of the high byte is 0 or 1.
	always_comb begin
		if (km_rd_data[15:12] == kmeg_pkg::NIB_LEFT
				|| km_rd_data[15:12] == kmeg_pkg::NIB_RIGHT) begin
			mods_d = km_rd_data[11:8];
		end else begin
			mods_d = 4'd0;
		end
	end

	assign km_wr_addr = KM_AW'(KM_AW'(item.row[ROW_AW-1:0]) * KM_AW'(COLS)
		+ KM_AW'(item.map_col));
	assign km_rd_addr = KM_AW'(KM_AW'(row_q[ROW_AW-1:0]) * KM_AW'(COLS)
		+ KM_AW'(col_sel));

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			kmeg_pkg::ST_IDLE: begin
				if (accept && item.op == kmeg_pkg::OP_SCAN) begin
					state_nx = kmeg_pkg::ST_LOAD;
				end
			end
			kmeg_pkg::ST_LOAD: state_nx = kmeg_pkg::ST_SCAN;
			kmeg_pkg::ST_SCAN: begin
				if (diff_q != '0) begin
					state_nx = kmeg_pkg::ST_CODE;
				end else if (eos_q && changed_q) begin
					state_nx = kmeg_pkg::ST_REPORT;
				end else begin
					state_nx = kmeg_pkg::ST_IDLE;
				end
			end
			kmeg_pkg::ST_CODE: state_nx = kmeg_pkg::ST_EMIT;
			kmeg_pkg::ST_EMIT: begin
				if (slot_free && mods_q == 4'd0) begin
					state_nx = kmeg_pkg::ST_SCAN;
				end
			end
			kmeg_pkg::ST_REPORT: begin
				if (slot_free) begin
					state_nx = kmeg_pkg::ST_IDLE;
				end
			end
			default: state_nx = kmeg_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		item_ready = 1'b0;
		ks_rd_en   = 1'b0;
		ks_wr_en   = 1'b0;
		km_wr_en   = 1'b0;
		km_rd_en   = 1'b0;
		emit       = 1'b0;
		emit_item  = '0;
		unique case (state_q)
			kmeg_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				ks_rd_en   = accept && item.op == kmeg_pkg::OP_SCAN && item_row_ok;
				km_wr_en   = accept && item.op == kmeg_pkg::OP_WRITE && item_row_ok
					&& {1'b0, item.map_col} < 4'(COLS);
			end
			kmeg_pkg::ST_LOAD: ks_wr_en = row_ok_q;
			kmeg_pkg::ST_SCAN: km_rd_en = diff_q != '0;
			kmeg_pkg::ST_CODE: begin
			end
			kmeg_pkg::ST_EMIT: begin
				emit              = slot_free;
				emit_item.kind    = kmeg_pkg::KIND_KEY;
				emit_item.pressed = press_q;
				if (mods_q != 4'd0) begin
					emit_item.usage = (right_q ? kmeg_pkg::MOD_RIGHT_BASE
						: kmeg_pkg::MOD_LEFT_BASE) + 8'(mod_sel);
					emit_item.last  = 1'b0;
				end else begin
					emit_item.usage = usage_q;
					// A key event implies a change, so a report follows at end of scan.
					emit_item.last  = diff_q == '0 && !eos_q;
				end
			end
			kmeg_pkg::ST_REPORT: begin
				emit              = slot_free;
				emit_item.kind    = kmeg_pkg::KIND_REPORT;
				emit_item.usage   = 8'h00;
				emit_item.pressed = 1'b0;
				emit_item.last    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= kmeg_pkg::ST_IDLE;
			changed_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == kmeg_pkg::ST_LOAD && diff_d != '0) begin
				changed_q <= 1'b1;
			end else if (state_q == kmeg_pkg::ST_SCAN && diff_q == '0 && eos_q) begin
				changed_q <= 1'b0;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= item.row;
			row_ok_q <= item_row_ok;
			lev_q    <= item.col_levels[COLS-1:0];
			eos_q    <= item.end_of_scan;
		end
		if (state_q == kmeg_pkg::ST_LOAD) begin
			now_q  <= now_d;
			diff_q <= diff_d;
		end
		if (state_q == kmeg_pkg::ST_SCAN && diff_q != '0) begin
			press_q <= now_q[col_sel];
			diff_q  <= diff_q & (diff_q - COLS'(1));
		end
		if (state_q == kmeg_pkg::ST_CODE) begin
			mods_q  <= mods_d;
			right_q <= km_rd_data[15:12] == kmeg_pkg::NIB_RIGHT;
			usage_q <= km_rd_data[7:0];
		end
		if (state_q == kmeg_pkg::ST_EMIT && slot_free && mods_q != 4'd0) begin
			mods_q <= mods_q & (mods_q - 4'd1);
		end
		if (emit) begin
			result_q <= emit_item;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	kmeg_key_mem #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_key_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (ks_rd_en),
		.rd_addr(item.row[ROW_AW-1:0]),
		.rd_data(ks_rd_data),
		.wr_en  (ks_wr_en),
		.wr_addr(row_q[ROW_AW-1:0]),
		.wr_data(now_d)
	);

	kmeg_keymap_mem #(
		.DEPTH(KM_DEPTH)
	) u_keymap_mem (
		.clk    (clk),
		.wr_en  (km_wr_en),
		.wr_addr(km_wr_addr),
		.wr_data(item.map_code),
		.rd_en  (km_rd_en),
		.rd_addr(km_rd_addr),
		.rd_data(km_rd_data)
	);

endmodule

// ===== hdl/kmeg_key_mem.sv =====
// Pressed-key memory: one row of column bits per matrix row, registered read.
// Per-row valid flops make unwritten rows read as no keys pressed.
// Depends on nothing but its parameters.
module kmeg_key_mem #(
	parameter int ROWS = 8,
	parameter int COLS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_addr,
	output logic [COLS-1:0]                     rd_data,
	input  logic                                wr_en,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_addr,
	input  logic [COLS-1:0]                     wr_data
);

	logic [COLS-1:0] mem [ROWS];
	logic [ROWS-1:0] vld_q;
	logic [COLS-1:0] mem_rd_q;
	logic            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_rd_q : '0;

endmodule

// ===== hdl/kmeg_keymap_mem.sv =====
// Keymap memory: 16-bit keycodes, one write and one registered read port.
// Contents are undefined until written. Depends on nothing but DEPTH.
module kmeg_keymap_mem #(
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [15:0]                           wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [15:0]                           rd_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/kmeg_checker.sv =====
// Port-level checker for the key matrix event generator, bound to the top level.
// Depends on kmeg_pkg and the assertion macros in key_matrix_event_generator_assert.svh.
`include "key_matrix_event_generator_assert.svh"

module kmeg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input kmeg_pkg::in_item_t  item,
	input logic                result_valid,
	input logic                result_ready,
	input kmeg_pkg::out_item_t result
);

	`KMEG_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result item changed")

	`KMEG_ASSERT_NOW(a_report_form, result_valid && result.kind == kmeg_pkg::KIND_REPORT, result.usage == 8'h00 && !result.pressed && result.last, "malformed report request")

	`KMEG_ASSERT_NEXT(a_scan_busy, item_valid && item_ready && item.op == kmeg_pkg::OP_SCAN, !item_ready, "scan item did not hold off the next item")

	`KMEG_ASSERT_NOW(a_mid_item_busy, result_valid && !result.last, !item_ready, "new item taken before the last result")

endmodule

bind key_matrix_event_generator kmeg_checker u_kmeg_checker (.*);

// ===== verif/tb_key_matrix_event_generator.sv =====
// Testbench for key_matrix_event_generator: loads keymap entries, scans matrix rows and
// checks every key usage and report item against a cycle-free prediction of the block.
// Depends on kmeg_pkg and the RTL of the block only.
module tb_key_matrix_event_generator;

	localparam int ROWS        = kmeg_pkg::ROWS_DEF;
	localparam int COLS        = kmeg_pkg::COLS_DEF;
	localparam int ITEM_TARGET = 330;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 100;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	kmeg_pkg::in_item_t  item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	kmeg_pkg::out_item_t result;

	key_matrix_event_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int cycle_count = 0;
	int error_count = 0;

	// In the quiet window at the end of each period, neither side idles.
	wire quiet_window = (cycle_count % 3000) >= 2000;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Items waiting to be offered, and the events the block owes us.
	kmeg_pkg::in_item_t  matrix_items[$];
	kmeg_pkg::out_item_t expected_events[$];

	// Predicted state of the block.
	logic [7:0]  pressed_bits [0:ROWS-1];
	logic [15:0] keycodes [0:ROWS*COLS-1];
	bit          changed_in_scan;

	// What the stimulus has planned so far: pressed keys and written keymap entries.
	logic [7:0] plan_pressed [0:ROWS-1];
	logic [7:0] map_written [0:ROWS-1];

	function automatic kmeg_pkg::out_item_t make_event(logic kind, logic [7:0] usage,
			logic pressed);
		kmeg_pkg::out_item_t ev;
		ev.kind    = kind;
		ev.usage   = usage;
		ev.pressed = pressed;
		ev.last    = 1'b0;
		return ev;
	endfunction

	function automatic void predict_events(kmeg_pkg::in_item_t it);
		kmeg_pkg::out_item_t evs[$];
		logic [7:0]  now_pressed;
		logic [15:0] code;
		logic [7:0]  hi;
		logic [7:0]  base;
		bit          mods;
		int          r;
		if (it.op == kmeg_pkg::OP_WRITE) begin
			if (it.row < ROWS && it.map_col < COLS)
				keycodes[int'(it.row) * COLS + int'(it.map_col)] = it.map_code;
			return;
		end
		r = int'(it.row);
		if (r < ROWS) begin
			now_pressed = ~it.col_levels;
			for (int c = 0; c < COLS; c++) begin
				if (now_pressed[c] != pressed_bits[r][c]) begin
					pressed_bits[r][c] = now_pressed[c];
					code = keycodes[r * COLS + c];
					hi   = code[15:8];
					mods = (hi != 8'h00) && (hi[7:4] == kmeg_pkg::NIB_LEFT
						|| hi[7:4] == kmeg_pkg::NIB_RIGHT);
					base = (hi[7:4] == kmeg_pkg::NIB_LEFT) ? kmeg_pkg::MOD_LEFT_BASE
						: kmeg_pkg::MOD_RIGHT_BASE;
					for (int i = 0; i < 4; i++)
						if (mods && hi[i])
							evs.push_back(make_event(kmeg_pkg::KIND_KEY, base + 8'(i),
								now_pressed[c]));
					evs.push_back(make_event(kmeg_pkg::KIND_KEY, code[7:0], now_pressed[c]));
					changed_in_scan = 1'b1;
				end
			end
		end
		if (it.end_of_scan) begin
			if (changed_in_scan)
				evs.push_back(make_event(kmeg_pkg::KIND_REPORT, 8'h00, 1'b0));
			changed_in_scan = 1'b0;
		end
		if (evs.size() > 0)
			evs[evs.size()-1].last = 1'b1;
		foreach (evs[i])
			expected_events.push_back(evs[i]);
	endfunction

	function automatic void queue_write(logic [3:0] row, logic [2:0] col, logic [15:0] code);
		kmeg_pkg::in_item_t it;
		it.op          = kmeg_pkg::OP_WRITE;
		it.row         = row;
		it.col_levels  = 8'($urandom);
		it.end_of_scan = 1'($urandom);
		it.map_col     = col;
		it.map_code    = code;
		if (row < ROWS)
			map_written[row][col] = 1'b1;
		matrix_items.push_back(it);
	endfunction

	// Only keys whose keymap entry has been written may change state.
	function automatic void queue_scan(logic [3:0] row, logic [7:0] levels, logic eos);
		kmeg_pkg::in_item_t it;
		it.op          = kmeg_pkg::OP_SCAN;
		it.row         = row;
		it.col_levels  = levels;
		it.end_of_scan = eos;
		it.map_col     = 3'($urandom);
		it.map_code    = 16'($urandom);
		if (row < ROWS)
			plan_pressed[row] = ~levels;
		matrix_items.push_back(it);
	endfunction

	// Driver: a new item is offered only when the slot is empty or was just taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready)
				predict_events(item);
			if (!item_valid || item_ready) begin
				if (matrix_items.size() != 0 && (quiet_window || $urandom_range(99) >= 8)) begin
					item_valid <= 1'b1;
					item       <= matrix_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest expected event.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result: kind %0d usage %0h pressed %0d last %0d",
						result.kind, result.usage, result.pressed, result.last);
					error_count++;
				end else begin
					if (result.kind !== expected_events[0].kind) begin
						$error("kind mismatch: expected %0d, actual %0d",
							expected_events[0].kind, result.kind);
						error_count++;
					end
					if (result.usage !== expected_events[0].usage) begin
						$error("usage mismatch: expected %0h, actual %0h",
							expected_events[0].usage, result.usage);
						error_count++;
					end
					if (result.pressed !== expected_events[0].pressed) begin
						$error("pressed mismatch: expected %0d, actual %0d",
							expected_events[0].pressed, result.pressed);
						error_count++;
					end
					if (result.last !== expected_events[0].last) begin
						$error("last mismatch: expected %0d, actual %0d",
							expected_events[0].last, result.last);
						error_count++;
					end
					void'(expected_events.pop_front());
				end
			end
			result_ready <= quiet_window || $urandom_range(99) >= 8;
		end
	end

	initial begin
		logic [7:0]  hi;
		logic [7:0]  levels;
		logic [7:0]  next_pressed;
		logic [3:0]  row;
		int          sweep_end;
		bit          sweep_eos;

		for (int r = 0; r < ROWS; r++) begin
			pressed_bits[r] = 8'h00;
			plan_pressed[r] = 8'h00;
			map_written[r]  = 8'h00;
		end
		for (int i = 0; i < ROWS * COLS; i++)
			keycodes[i] = 16'h0000;
		changed_in_scan = 1'b0;

		// Directed part: every kind of keycode on row 0, full modifier load on row 1.
		queue_write(4'd0, 3'd0, 16'h0000);
		queue_write(4'd0, 3'd1, 16'h0F04);
		queue_write(4'd0, 3'd2, 16'h1F05);
		queue_write(4'd0, 3'd3, 16'h2A06);
		queue_write(4'd0, 3'd4, 16'hFFFF);
		queue_write(4'd0, 3'd5, 16'h0139);
		queue_write(4'd0, 3'd6, 16'h1880);
		queue_write(4'd0, 3'd7, 16'h00FF);
		queue_write(4'd9, 3'd2, 16'hABCD);
		queue_scan(4'd0, 8'h00, 1'b0);
		queue_scan(4'd12, 8'h00, 1'b1);
		queue_scan(4'd0, 8'hFF, 1'b1);
		queue_scan(4'd0, 8'hFF, 1'b1);
		for (int c = 0; c < COLS; c++)
			queue_write(4'd1, 3'(c), {(c % 2 == 0) ? 8'h0F : 8'h1F, 8'h10 + 8'(c)});
		queue_scan(4'd1, 8'h00, 1'b1);
		queue_scan(4'd1, 8'hFF, 1'b0);
		queue_scan(4'd15, 8'h55, 1'b1);

		// Random part: mostly full row sweeps ending in end_of_scan, with keymap loads,
		// rows beyond the matrix, and sweeps cut short.
		while (matrix_items.size() < ITEM_TARGET) begin
			if ($urandom_range(99) < 30) begin
				row = ($urandom_range(99) < 80) ? 4'($urandom_range(ROWS - 1))
					: 4'($urandom_range(15, 8));
				for (int c = 0; c < COLS; c++) begin
					if ($urandom_range(99) < 70) begin
						case ($urandom_range(3))
							0: hi = 8'h00;
							1: hi = {kmeg_pkg::NIB_LEFT, 4'($urandom)};
							2: hi = {kmeg_pkg::NIB_RIGHT, 4'($urandom)};
							default: hi = 8'($urandom);
						endcase
						queue_write(row, 3'(c), {hi, 8'($urandom)});
					end
				end
			end else begin
				sweep_end = ROWS - 1;
				sweep_eos = 1'b1;
				if ($urandom_range(99) < 15) begin
					sweep_end = $urandom_range(ROWS - 2);
					sweep_eos = 1'($urandom);
				end
				for (int r = 0; r <= sweep_end; r++) begin
					if ($urandom_range(99) < 10)
						queue_scan(4'($urandom_range(15, 8)), 8'($urandom), 1'($urandom));
					next_pressed = plan_pressed[r];
					if ($urandom_range(99) < 5) begin
						next_pressed = plan_pressed[r] ^ map_written[r];
					end else begin
						for (int c = 0; c < COLS; c++)
							if (map_written[r][c] && $urandom_range(3) == 0)
								next_pressed[c] = ~next_pressed[c];
					end
					levels = ~next_pressed;
					queue_scan(4'(r), levels, (r == sweep_end) ? sweep_eos : 1'b0);
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (matrix_items.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
